### hdl/btnrep_pkg.sv
// ============================================================================
// btnrep_pkg
// Shared types, constants and the key code table of the button auto-repeat
// tracker.
// ============================================================================
package btnrep_pkg;

   // Number of tracked buttons by default and width of the mask fields
   localparam int NUM_BUTTONS_DEF = 20;
   localparam int FIELD_W         = 20;
   localparam int BTN_ID_W        = 5;

   // Beat widths
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 80;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   // Item kinds carried on req_tuser
   localparam logic OP_POLL  = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // Raw event type of a key
   localparam logic [15:0] KEY_TYPE = 16'h0001;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0]  REG_DELAY      = 8'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_INTERVAL   = 8'd1;
   localparam logic [CSR_DATA_W-1:0] DELAY_RST      = 16'd300;
   localparam logic [CSR_DATA_W-1:0] INTERVAL_RST   = 16'd100;

   // Controller to datapath commands
   typedef struct packed {
      logic poll_start;   // latch poll time, clear flags, clear sweep counter
      logic ev_apply;     // apply the key event on the request beat
      logic rd_en;        // read deadline at sweep counter, advance counter
      logic load_out;     // copy state into the result register
   } btnrep_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last;         // sweep counter on the last button
      logic out_free;     // result register can take a new beat
   } btnrep_sts_type;

   typedef struct packed {
      logic                hit;
      logic [BTN_ID_W-1:0] id;
   } btnrep_lookup_type;

   // Key code to button bit
   function automatic btnrep_lookup_type lookup_button(input logic [15:0] code);
      btnrep_lookup_type r;
      r.hit = 1'b1;
      r.id  = '0;
      unique case (code)
         16'd544: r.id = 5'd0;   // up
         16'd545: r.id = 5'd1;   // down
         16'd546: r.id = 5'd2;   // left
         16'd547: r.id = 5'd3;   // right
         16'd305: r.id = 5'd4;   // A
         16'd304: r.id = 5'd5;   // B
         16'd307: r.id = 5'd6;   // X
         16'd308: r.id = 5'd7;   // Y
         16'd315: r.id = 5'd8;   // start
         16'd314: r.id = 5'd9;   // select
         16'd316: r.id = 5'd10;  // menu
         16'd310: r.id = 5'd11;  // L1
         16'd312: r.id = 5'd12;  // L2
         16'd317: r.id = 5'd13;  // L3
         16'd311: r.id = 5'd14;  // R1
         16'd313: r.id = 5'd15;  // R2
         16'd318: r.id = 5'd16;  // R3
         16'd115: r.id = 5'd17;  // plus
         16'd114: r.id = 5'd18;  // minus
         16'd116: r.id = 5'd19;  // power
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### hdl/btnrep_ctrl.sv
// ============================================================================
// btnrep_ctrl
// Sequencer: takes one request beat at a time, walks the deadline sweep of a
// poll and hands the result to the output register.
// ============================================================================
module btnrep_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,
   input  btnrep_pkg::btnrep_sts_type sts,
   output btnrep_pkg::btnrep_cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.poll_start = 1'b0;
      cmd.ev_apply   = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.load_out   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == btnrep_pkg::OP_POLL) begin
                  cmd.poll_start = 1'b1;
                  state_in       = S_SWEEP;
               end else begin
                  cmd.ev_apply = 1'b1;
                  state_in     = S_DONE;
               end
            end
         end
         S_SWEEP: begin
            cmd.rd_en = 1'b1;
            if (sts.last) begin
               state_in = S_FLUSH;
            end
         end
         // last write-back of the sweep lands here
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/btnrep_dp.sv
// ============================================================================
// btnrep_dp
// Datapath: button state and flags, deadline memory with a two-stage sweep,
// configuration registers and the result register.
// ============================================================================
module btnrep_dp #(
   parameter int NUM_BUTTONS = btnrep_pkg::NUM_BUTTONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  btnrep_pkg::btnrep_cmd_type           cmd,
   output btnrep_pkg::btnrep_sts_type           sts,
   input  logic [btnrep_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                 csr_valid,
   input  logic [btnrep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btnrep_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [btnrep_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int FW    = btnrep_pkg::FIELD_W;

   // Configuration
   logic [15:0] delay_ff;
   logic [15:0] interval_ff;

   // Button state
   logic [31:0]            poll_time_ff, poll_time_in;
   logic [NUM_BUTTONS-1:0] held_ff, held_in;
   logic [NUM_BUTTONS-1:0] pressed_ff, pressed_in;
   logic [NUM_BUTTONS-1:0] released_ff, released_in;
   logic [NUM_BUTTONS-1:0] repeat_ff, repeat_in;

   // Sweep
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             wb_vld_ff;
   logic [IDX_W-1:0] wb_idx_ff;
   logic [31:0]      rd_data_ff;
   logic [31:0]      mem [NUM_BUTTONS];

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [btnrep_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // Request beat fields
   logic [31:0] now_ms;
   logic [15:0] ev_type;
   logic [15:0] ev_code;
   logic [31:0] ev_value;

   // Event decode
   btnrep_pkg::btnrep_lookup_type lk;
   logic                   ev_ok;
   logic                   ev_rel;
   logic [NUM_BUTTONS-1:0] ev_bit;
   logic                   press_new;

   // Write-back of the sweep
   logic                   wb_hit;
   logic [NUM_BUTTONS-1:0] wb_bit;

   // Memory write port
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [31:0]      mem_wdata;

   logic [31:0] held_ext, pressed_ext, released_ext, repeat_ext;

   assign now_ms   = req_tdata[31:0];
   assign ev_type  = req_tdata[47:32];
   assign ev_code  = req_tdata[63:48];
   assign ev_value = req_tdata[95:64];

   // Key event decode: values above one and unmapped codes drop out
   always_comb begin
      lk     = btnrep_pkg::lookup_button(ev_code);
      ev_rel = (ev_value == 32'd0);
      ev_ok  = (ev_type == btnrep_pkg::KEY_TYPE)
             && !(!ev_value[31] && (ev_value[30:1] != 30'd0))
             && lk.hit
             && (6'(lk.id) < 6'(NUM_BUTTONS));
      ev_bit    = NUM_BUTTONS'(1) << lk.id;
      press_new = ev_ok && !ev_rel && ((held_ff & ev_bit) == '0);
   end

   // Deadline compare on the entry read in the previous cycle
   assign wb_hit = wb_vld_ff && held_ff[wb_idx_ff] && (poll_time_ff >= rd_data_ff);
   assign wb_bit = NUM_BUTTONS'(1) << wb_idx_ff;

   // Memory write: arm on press, advance on repeat
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wb_idx_ff;
      mem_wdata = rd_data_ff + 32'(interval_ff);
      if (cmd.ev_apply && press_new) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(lk.id);
         mem_wdata = poll_time_ff + 32'(delay_ff);
      end else if (wb_hit) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

   // State and flag update
   always_comb begin
      poll_time_in = poll_time_ff;
      held_in      = held_ff;
      pressed_in   = pressed_ff;
      released_in  = released_ff;
      repeat_in    = repeat_ff;
      cnt_in       = cnt_ff;
      if (cmd.poll_start) begin
         poll_time_in = now_ms;
         pressed_in   = '0;
         released_in  = '0;
         repeat_in    = '0;
         cnt_in       = '0;
      end
      if (cmd.rd_en) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
      if (wb_hit) begin
         repeat_in = repeat_ff | wb_bit;
      end
      if (cmd.ev_apply && ev_ok) begin
         if (ev_rel) begin
            held_in     = held_ff & ~ev_bit;
            repeat_in   = repeat_ff & ~ev_bit;
            released_in = released_ff | ev_bit;
         end else if (press_new) begin
            held_in    = held_ff | ev_bit;
            pressed_in = pressed_ff | ev_bit;
            repeat_in  = repeat_ff | ev_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_time_ff <= '0;
         held_ff      <= '0;
         pressed_ff   <= '0;
         released_ff  <= '0;
         repeat_ff    <= '0;
         wb_vld_ff    <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         poll_time_ff <= poll_time_in;
         held_ff      <= held_in;
         pressed_ff   <= pressed_in;
         released_ff  <= released_in;
         repeat_ff    <= repeat_in;
         wb_vld_ff    <= cmd.rd_en;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_idx_ff <= cnt_ff;
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= btnrep_pkg::DELAY_RST;
         interval_ff <= btnrep_pkg::INTERVAL_RST;
      end else if (csr_valid) begin
         if (csr_index == btnrep_pkg::REG_DELAY) begin
            delay_ff <= csr_wdata;
         end
         if (csr_index == btnrep_pkg::REG_INTERVAL) begin
            interval_ff <= csr_wdata;
         end
      end
   end

   // Result register
   assign held_ext     = 32'(held_ff);
   assign pressed_ext  = 32'(pressed_ff);
   assign released_ext = 32'(released_ff);
   assign repeat_ext   = 32'(repeat_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {repeat_ext[FW-1:0], released_ext[FW-1:0],
                         pressed_ext[FW-1:0], held_ext[FW-1:0]};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.last     = (cnt_ff == IDX_W'(NUM_BUTTONS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

### hdl/button_event_autorepeat_tracker_top.sv
// ============================================================================
// button_event_autorepeat_tracker_top
// Tracks held buttons from raw key events, with per-poll pressed, released
// and auto-repeat flags.
// ============================================================================
//
// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   req_tuser: op; req_tdata: now_ms,
//                                           event_type, event_code, event_value
// rsp       out  rsp_tvalid / rsp_tready   rsp_tdata: held_mask, pressed_now,
//                                           released_now, repeated_now
// csr       in   csr_valid / csr_ready     csr_index, csr_wdata
//
// One request beat is worked at a time. An event beat is applied as it is taken;
// a poll beat runs the deadline sweep, which reads one memory entry per cycle,
// before its result goes to the output register.
// A result waiting in the output register does not block the next request;
// only the following result waits for it.
// Reset is synchronous; the deadline memory needs no clearing.
// csr_ready is always high.
//
module button_event_autorepeat_tracker_top #(
   parameter int NUM_BUTTONS = btnrep_pkg::NUM_BUTTONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // now_ms[31:0], event_type[47:32], event_code[63:48], event_value[95:64]
   input  logic [btnrep_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // held_mask[19:0], pressed_now[39:20], released_now[59:40],
   // repeated_now[79:60]
   output logic [btnrep_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [btnrep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btnrep_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   btnrep_pkg::btnrep_cmd_type cmd;
   btnrep_pkg::btnrep_sts_type sts;

   assign csr_ready = 1'b1;

   // Sequencer
   btnrep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath
   btnrep_dp #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hdl/btnrep_chk.sv
// ============================================================================
// btnrep_chk
// Port-level checks of the button auto-repeat tracker, bound to the top level.
// ============================================================================
module btnrep_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [btnrep_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // One request at a time: no beat right after an accepted one
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   // A repeat flag only stands on a held button
   a_rep_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[79:60] & ~rsp_tdata[19:0]) == 20'd0))
      else $error("repeat flag on a button that is not held");

   // Reset empties the result register
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind button_event_autorepeat_tracker_top btnrep_chk u_btnrep_chk (.*);

### sim/button_tracker_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// button_tracker_checker
// Watches the request, result and register channels of the button tracker.
// It keeps its own copy of the held buttons, poll flags and repeat deadlines,
// predicts one mask beat for every accepted request beat and compares each
// result beat, field by field, with the oldest prediction.
// ============================================================================
module button_tracker_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // now_ms[31:0], event_type[47:32], event_code[63:48], event_value[95:64]
   input  logic [btnrep_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op[0]
   input  logic                                 req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // held_mask[19:0], pressed_now[39:20], released_now[59:40],
   // repeated_now[79:60]
   input  logic [btnrep_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [btnrep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btnrep_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                   mismatch_count,
   output int                                   masks_pending
);
   import btnrep_pkg::*;

   localparam int NUM_KEYS = NUM_BUTTONS_DEF;

   // key code of each button bit, bit 0 first
   localparam logic [15:0] KEY_CODES [0:NUM_KEYS-1] = '{
      16'd544, 16'd545, 16'd546, 16'd547, 16'd305, 16'd304, 16'd307,
      16'd308, 16'd315, 16'd314, 16'd316, 16'd310, 16'd312, 16'd317,
      16'd311, 16'd313, 16'd318, 16'd115, 16'd114, 16'd116
   };

   // result beat layout, held mask in the low bits
   typedef struct packed {
      logic [FIELD_W-1:0] repeated;
      logic [FIELD_W-1:0] released;
      logic [FIELD_W-1:0] pressed;
      logic [FIELD_W-1:0] held;
   } button_masks_type;

   logic [CSR_DATA_W-1:0] delay_ms;
   logic [CSR_DATA_W-1:0] interval_ms;
   logic [FIELD_W-1:0]    held;
   logic [FIELD_W-1:0]    pressed;
   logic [FIELD_W-1:0]    released;
   logic [FIELD_W-1:0]    repeated;
   logic [31:0]           deadline [0:NUM_KEYS-1];
   logic [31:0]           poll_time;
   button_masks_type      expected_masks [$];

   // button bit of a key code, -1 when the code is not in the table
   function automatic int key_index(input logic [15:0] code);
      int idx;
      idx = -1;
      for (int i = 0; i < NUM_KEYS; i++)
         if (idx < 0 && KEY_CODES[i] == code)
            idx = i;
      return idx;
   endfunction

   // apply one request beat to the tracked state and queue its masks
   task automatic track_item(input logic op, input logic [REQ_TDATA_W-1:0] data);
      logic [31:0] now;
      logic [15:0] etype;
      logic [15:0] code;
      logic [31:0] value;
      int          id;
      now   = data[31:0];
      etype = data[47:32];
      code  = data[63:48];
      value = data[95:64];
      if (op == OP_POLL) begin
         poll_time = now;
         pressed   = '0;
         released  = '0;
         repeated  = '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            if (held[i] && now >= deadline[i]) begin
               repeated[i] = 1'b1;
               deadline[i] = deadline[i] + {16'd0, interval_ms};
            end
         end
      end else if (etype == KEY_TYPE && (value[31] || value <= 32'd1)) begin
         // negative values press like 1; positive values above 1 drop out
         id = key_index(code);
         if (id >= 0) begin
            if (value == '0) begin
               held[id]     = 1'b0;
               repeated[id] = 1'b0;
               released[id] = 1'b1;
            end else if (!held[id]) begin
               pressed[id]  = 1'b1;
               repeated[id] = 1'b1;
               held[id]     = 1'b1;
               deadline[id] = poll_time + {16'd0, delay_ms};
            end
         end
      end
      expected_masks.push_back('{repeated: repeated, released: released,
                                 pressed: pressed, held: held});
   endtask

   // compare a result beat with the oldest prediction
   task automatic compare_masks(input button_masks_type got);
      button_masks_type want;
      if (expected_masks.size() == 0) begin
         $error("result beat %h with no request waiting", got);
         mismatch_count++;
      end else begin
         want = expected_masks.pop_front();
         if (got.held !== want.held) begin
            $error("held_mask: expected %h, got %h", want.held, got.held);
            mismatch_count++;
         end
         if (got.pressed !== want.pressed) begin
            $error("pressed_now: expected %h, got %h", want.pressed, got.pressed);
            mismatch_count++;
         end
         if (got.released !== want.released) begin
            $error("released_now: expected %h, got %h", want.released, got.released);
            mismatch_count++;
         end
         if (got.repeated !== want.repeated) begin
            $error("repeated_now: expected %h, got %h", want.repeated, got.repeated);
            mismatch_count++;
         end
      end
   endtask

   // handshakes are taken at the rising edge, before the block updates
   always @(posedge clock) begin
      if (reset) begin
         delay_ms       = DELAY_RST;
         interval_ms    = INTERVAL_RST;
         held           = '0;
         pressed        = '0;
         released       = '0;
         repeated       = '0;
         poll_time      = '0;
         mismatch_count = 0;
         for (int i = 0; i < NUM_KEYS; i++)
            deadline[i] = '0;
         expected_masks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            compare_masks(button_masks_type'(rsp_tdata));
         if (req_tvalid && req_tready)
            track_item(req_tuser, req_tdata);
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_DELAY)
               delay_ms = csr_wdata;
            else if (csr_index == REG_INTERVAL)
               interval_ms = csr_wdata;
         end
      end
      masks_pending = expected_masks.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives the button tracker with a directed opening (extreme times, time wrap,
// negative and ignored event values, axis and unknown events, unmapped codes,
// presses of held buttons, releases of idle ones) and then with random polls
// and key events under several register settings and idling patterns.
// ============================================================================
module tb;
   import btnrep_pkg::*;

   localparam int NUM_KEYS    = NUM_BUTTONS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 55;
   localparam int NUM_PHASES  = 6;

   localparam logic [15:0]          AXIS_TYPE        = 16'h0003;
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_REG = REG_INTERVAL + 1'b1;

   // key codes used for well-formed events, bit 0 first
   localparam logic [15:0] KEY_CODES [0:NUM_KEYS-1] = '{
      16'd544, 16'd545, 16'd546, 16'd547, 16'd305, 16'd304, 16'd307,
      16'd308, 16'd315, 16'd314, 16'd316, 16'd310, 16'd312, 16'd317,
      16'd311, 16'd313, 16'd318, 16'd115, 16'd114, 16'd116
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int          mismatch_count;
   int          masks_pending;
   int          send_idle_pct;
   int          stall_pct;
   int          cycle_count;
   logic [31:0] clock_ms;   // millisecond time base of the stimulus

   button_event_autorepeat_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   button_tracker_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .masks_pending  (masks_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request beat, with random gaps and the odd full hold-off
   task automatic send_beat(input logic op, input logic [31:0] now,
                            input logic [15:0] etype, input logic [15:0] code,
                            input logic [31:0] value);
      @(negedge clock);
      if ($urandom_range(59) == 0) begin
         // hold off until every result is back
         req_tvalid <= 1'b0;
         do @(negedge clock); while (masks_pending != 0);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, code, etype, now};
      do @(posedge clock); while (!req_tready);
   endtask

   // unused event fields carry random bits
   task automatic send_poll(input logic [31:0] now);
      send_beat(OP_POLL, now, 16'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic send_key(input logic [15:0] etype, input logic [15:0] code,
                           input logic [31:0] value);
      send_beat(OP_EVENT, $urandom, etype, code, value);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (masks_pending != 0) @(negedge clock);
   endtask

   // mostly polls with advancing time and clean press/release beats,
   // with some noise events; noise does not count toward the phase total
   task automatic send_random_item(output bit counted);
      int          pick;
      logic [15:0] etype;
      logic [15:0] code;
      logic [31:0] value;
      pick    = $urandom_range(99);
      counted = 1'b1;
      if (pick < 35) begin
         pick = $urandom_range(99);
         if (pick < 70)
            clock_ms += $urandom_range(120);
         else if (pick < 90)
            clock_ms += $urandom_range(1000);
         else if (pick < 98)
            clock_ms += $urandom_range(70000);
         else
            clock_ms = $urandom;
         send_poll(clock_ms);
      end else if (pick < 85) begin
         value = ($urandom_range(99) < 55) ? 32'd1 : 32'd0;
         send_key(KEY_TYPE, KEY_CODES[$urandom_range(NUM_KEYS - 1)], value);
      end else begin
         counted = 1'b0;
         case ($urandom_range(2))
            0:       etype = KEY_TYPE;
            1:       etype = AXIS_TYPE;
            default: etype = 16'($urandom);
         endcase
         code = $urandom_range(1) ? KEY_CODES[$urandom_range(NUM_KEYS - 1)]
                                  : 16'($urandom);
         case ($urandom_range(3))
            0:       value = $urandom;
            1:       value = $urandom | 32'h8000_0000;       // negative: press
            2:       value = $urandom_range(32'h7FFF_FFFF, 2); // dropped
            default: value = $urandom_range(1);
         endcase
         send_key(etype, code, value);
      end
   endtask

   // directed opening under the reset register values
   task automatic run_directed();
      send_poll(32'd0);
      send_key(KEY_TYPE, KEY_CODES[0], 32'd1);                  // press up
      send_key(KEY_TYPE, KEY_CODES[0], 32'd1);                  // already held
      send_key(KEY_TYPE, KEY_CODES[NUM_KEYS-1], 32'hFFFF_FFFF); // -1 presses
      send_key(KEY_TYPE, KEY_CODES[1], 32'd2);                  // autorepeat code
      send_key(KEY_TYPE, KEY_CODES[1], 32'h7FFF_FFFF);
      send_key(AXIS_TYPE, KEY_CODES[0], 32'd0);                 // axis event
      send_key(16'hFFFF, 16'hFFFF, 32'd0);                      // unknown type
      send_key(KEY_TYPE, 16'd0, 32'd1);                         // unmapped codes
      send_key(KEY_TYPE, 16'hFFFF, 32'd1);
      send_poll(32'd299);                                       // one short
      send_poll(32'd300);                                       // deadline hit
      send_poll(32'd399);
      send_key(KEY_TYPE, KEY_CODES[1], 32'd0);                  // release idle
      send_key(KEY_TYPE, KEY_CODES[0], 32'd0);
      send_key(KEY_TYPE, KEY_CODES[4], 32'h8000_0000);          // most negative
      send_poll(32'hFFFF_FF00);
      send_key(KEY_TYPE, KEY_CODES[5], 32'd1);                  // deadline wraps
      send_poll(32'hFFFF_FFFF);
      send_poll(32'd0);                                         // time wraps
      send_poll(32'd44);
      send_key(KEY_TYPE, KEY_CODES[NUM_KEYS-1], 32'd0);
      send_key(KEY_TYPE, KEY_CODES[4], 32'd0);
      send_key(KEY_TYPE, KEY_CODES[5], 32'd0);
      clock_ms = 32'd44;
   endtask

   initial begin
      int                    done;
      bit                    counted;
      logic [CSR_DATA_W-1:0] delay_val;
      logic [CSR_DATA_W-1:0] interval_val;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = 1'b0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      clock_ms      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               delay_val = '0;  interval_val = 16'd1;
               send_idle_pct = 0;  stall_pct = 0;
            end
            1: begin
               delay_val = '1;  interval_val = '1;
               send_idle_pct = 57;  stall_pct = 0;
            end
            2: begin
               // zero interval: held buttons repeat on every poll once their delay has passed
               delay_val = DELAY_RST;  interval_val = '0;
               send_idle_pct = 0;  stall_pct = 57;
            end
            3: begin
               delay_val = 16'($urandom);  interval_val = 16'($urandom_range(65535, 1));
               send_idle_pct = 10;  stall_pct = 10;
            end
            4: begin
               delay_val = 16'($urandom_range(400));
               interval_val = 16'($urandom_range(200, 1));
               send_idle_pct = 0;  stall_pct = 0;
            end
            default: begin
               delay_val = 16'($urandom_range(150));
               interval_val = 16'($urandom_range(60, 1));
               send_idle_pct = 57;  stall_pct = 57;
            end
         endcase
         wait_drained();
         write_reg(REG_DELAY, delay_val);
         write_reg(REG_INTERVAL, interval_val);
         if (phase == 3)
            write_reg(CSR_IDX_W'($urandom_range(255, FIRST_UNUSED_REG)), 16'($urandom));
         done = 0;
         while (done < PHASE_ITEMS) begin
            send_random_item(counted);
            if (counted)
               done++;
         end
      end

      wait_drained();
      repeat (30) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
